// ===== hdl/dsh_pkg.sv =====
// shared types, register codes and constants of the decaying sample histogram
`timescale 1ns / 1ps

package dsh_pkg;

	localparam int BINS_DEF = 256;
	localparam int CNT_W    = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VAL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VAL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_SCALE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_COUNT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_COUNT  = 3'd4;

	// register reset values
	localparam logic signed [15:0] MIN_VAL_RST     = 16'sh8000;
	localparam logic signed [15:0] MAX_VAL_RST     = 16'sh7FFF;
	localparam logic [31:0]        BIN_SCALE_RST   = 32'd256;
	localparam logic [31:0]        RESET_COUNT_RST = 32'd1048576;
	localparam logic [31:0]        BASE_COUNT_RST  = 32'd65536;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_RD,
		ST_UPD,
		ST_OUT,
		ST_PEAK,
		ST_PEAK_W,
		ST_WALK_RD,
		ST_WALK_GO,
		ST_WALK_W
	} ctl_state_t;

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_MUL,
		SC_CHK,
		SC_DIV
	} scl_state_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] x;
	} scl_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [CNT_W-1:0] y;
	} scl_rsp_t;

endpackage

// ===== hdl/decaying_sample_histogram.sv =====
// top level of the decaying sample histogram: control, registers and output stage
// a read passes ST_RD, ST_UPD; a push ST_MUL, ST_RD, ST_UPD (bin read-modify-write);
// a rejected push goes to ST_OUT; s_tready stays low until the result is loaded
// a push that hits reset_count rescales the peak, then walks all bins through the
// rescale unit, one multiply and a 32-step serial divide per bin unless it saturates
// reset: all control state clears at once, then a clearing pass over all bins
// zeroes the bin memory while s_tready stays low; config writes are taken throughout
`timescale 1ns / 1ps

module decaying_sample_histogram import dsh_pkg::*; #(
	parameter int BINS = BINS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // sample[15:0], read_index[23:16]
	input  logic [0:0]           s_tuser,   // kind[0]
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [71:0]          m_tdata,   // bin_index[7:0], bin_count[39:8], peak_count[71:40]
	output logic [1:0]           m_tuser    // in_range[0], rescaled[1]
);

	localparam int AW = $clog2(BINS);
	localparam int IW = (AW > 8) ? AW : 8;
	localparam logic [AW-1:0] LAST_BIN = AW'(BINS - 1);

	ctl_state_t state_q, state_d;

	// configuration registers
	logic signed [15:0] min_val_q;
	logic signed [15:0] max_val_q;
	logic [31:0]        bin_scale_q;
	logic [31:0]        reset_count_q;
	logic [31:0]        base_count_q;

	// per-item registers
	logic             kind_q;
	logic [7:0]       ridx_q;
	logic             rd_ok_q;
	logic             in_rng_q;
	logic [15:0]      diff_q;
	logic [31:0]      prod_q;
	logic [AW-1:0]    addr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             resc_q;

	// histogram state outside the memory
	logic [CNT_W-1:0] peak_q;
	logic [31:0]      samp_cnt_q;
	logic [AW-1:0]    walk_q;   // clearing pass and rescale walk address

	// output register
	logic             out_valid_q;
	logic             out_inr_q;
	logic [7:0]       out_idx_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic [CNT_W-1:0] out_peak_q;
	logic             out_resc_q;

	// input unpack
	logic               in_kind;
	logic signed [15:0] in_sample;
	logic [7:0]         in_ridx;
	logic               acc;
	logic               in_rng_c;

	assign in_kind   = s_tuser[0];
	assign in_sample = s_tdata[15:0];
	assign in_ridx   = s_tdata[23:16];
	assign s_tready  = (state_q == ST_IDLE);
	assign acc       = s_tvalid && s_tready;
	assign in_rng_c  = (in_sample >= min_val_q) && (in_sample < max_val_q);
	assign cfg_ready = 1'b1;

	// bin number from the registered product, saturated to the last bin
	logic [47:0]   prod_c;
	logic [AW-1:0] bin_c;
	logic [IW-1:0] ridx_w;
	logic [IW-1:0] addr_w;

	assign prod_c = 48'(diff_q) * 48'(bin_scale_q);
	assign bin_c  = (prod_q > 32'(BINS - 1)) ? LAST_BIN : prod_q[AW-1:0];
	assign ridx_w = IW'(ridx_q);
	assign addr_w = IW'(addr_q);

	// memory ports
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [CNT_W-1:0] wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [CNT_W-1:0] rd_data;

	dsh_bin_ram #(
		.DEPTH(BINS),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	scl_req_t sc_req;
	scl_rsp_t sc_rsp;

	dsh_scaler u_scaler (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (sc_req),
		.num   (base_count_q),
		.den   (reset_count_q),
		.rsp   (sc_rsp)
	);

	// update arithmetic for the read-modify-write beat
	logic [CNT_W-1:0] inc;
	logic [CNT_W-1:0] upd_cnt;
	logic [CNT_W-1:0] upd_peak;
	logic [31:0]      cnt_next;
	logic             trig;
	logic             walk_last;

	assign inc       = (rd_data == CNT_MAX) ? rd_data : rd_data + 1'b1;
	assign upd_cnt   = kind_q ? (rd_ok_q ? rd_data : '0) : inc;
	assign upd_peak  = (inc > peak_q) ? inc : peak_q;
	assign cnt_next  = samp_cnt_q + 32'd1;
	assign trig      = (reset_count_q != 32'd0) && (cnt_next == reset_count_q);
	assign walk_last = (walk_q == LAST_BIN);

	// output load
	logic             out_free;
	logic             out_load;
	logic             ld_inr;
	logic [7:0]       ld_idx;
	logic [CNT_W-1:0] ld_cnt;
	logic [CNT_W-1:0] ld_peak;
	logic             ld_resc;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		if (state_q == ST_UPD) begin
			// result straight from the update beat, no rescale on this path
			ld_inr  = !kind_q;
			ld_idx  = kind_q ? ridx_q : addr_w[7:0];
			ld_cnt  = upd_cnt;
			ld_peak = kind_q ? peak_q : upd_peak;
			ld_resc = 1'b0;
		end else begin
			ld_inr  = in_rng_q && !kind_q;
			ld_idx  = kind_q ? ridx_q : (in_rng_q ? addr_w[7:0] : 8'd0);
			ld_cnt  = cnt_q;
			ld_peak = peak_q;
			ld_resc = resc_q;
		end
	end

	// next state and control strobes
	always_comb begin
		state_d   = state_q;
		wr_en     = 1'b0;
		wr_addr   = walk_q;
		wr_data   = '0;
		rd_en     = 1'b0;
		rd_addr   = walk_q;
		sc_req    = '0;
		out_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				if (walk_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					if (in_kind) begin
						state_d = ST_RD;
					end else if (in_rng_c) begin
						state_d = ST_MUL;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_MUL: state_d = ST_RD;
			ST_RD: begin
				rd_en   = 1'b1;
				rd_addr = kind_q ? ridx_w[AW-1:0] : bin_c;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (!kind_q) begin
					wr_en   = 1'b1;
					wr_addr = addr_q;
					wr_data = inc;
				end
				if (!kind_q && trig) begin
					state_d = ST_PEAK;
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_PEAK: begin
				sc_req.start = 1'b1;
				sc_req.x     = peak_q;
				state_d      = ST_PEAK_W;
			end
			ST_PEAK_W: begin
				if (sc_rsp.done) begin
					state_d = ST_WALK_RD;
				end
			end
			ST_WALK_RD: begin
				rd_en   = 1'b1;
				state_d = ST_WALK_GO;
			end
			ST_WALK_GO: begin
				sc_req.start = 1'b1;
				sc_req.x     = rd_data;
				state_d      = ST_WALK_W;
			end
			ST_WALK_W: begin
				if (sc_rsp.done) begin
					wr_en   = 1'b1;
					wr_data = sc_rsp.y;
					if (walk_last) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_WALK_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			walk_q        <= '0;
			peak_q        <= '0;
			samp_cnt_q    <= '0;
			out_valid_q   <= 1'b0;
			min_val_q     <= MIN_VAL_RST;
			max_val_q     <= MAX_VAL_RST;
			bin_scale_q   <= BIN_SCALE_RST;
			reset_count_q <= RESET_COUNT_RST;
			base_count_q  <= BASE_COUNT_RST;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MIN_VAL:     min_val_q     <= cfg_data[15:0];
					REG_MAX_VAL:     max_val_q     <= cfg_data[15:0];
					REG_BIN_SCALE:   bin_scale_q   <= cfg_data;
					REG_RESET_COUNT: reset_count_q <= cfg_data;
					REG_BASE_COUNT:  base_count_q  <= cfg_data;
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: walk_q <= walk_last ? '0 : walk_q + 1'b1;
				ST_UPD: begin
					if (!kind_q) begin
						peak_q     <= upd_peak;
						samp_cnt_q <= trig ? base_count_q : cnt_next;
					end
				end
				ST_PEAK_W: begin
					if (sc_rsp.done) begin
						peak_q <= sc_rsp.y;
						walk_q <= '0;
					end
				end
				ST_WALK_W: begin
					if (sc_rsp.done) begin
						walk_q <= walk_last ? '0 : walk_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					kind_q   <= in_kind;
					ridx_q   <= in_ridx;
					rd_ok_q  <= 32'(in_ridx) < 32'(BINS);
					in_rng_q <= in_rng_c;
					diff_q   <= in_sample[15:0] - min_val_q[15:0];
					cnt_q    <= '0;
					resc_q   <= 1'b0;
				end
			end
			ST_MUL: prod_q <= prod_c[47:16];
			ST_RD:  addr_q <= bin_c;
			ST_UPD: begin
				cnt_q  <= upd_cnt;
				resc_q <= !kind_q && trig;
			end
			ST_WALK_W: begin
				// pick up the rescaled value of the bin this push hit
				if (sc_rsp.done && walk_q == addr_q) begin
					cnt_q <= sc_rsp.y;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_inr_q  <= ld_inr;
			out_idx_q  <= ld_idx;
			out_cnt_q  <= ld_cnt;
			out_peak_q <= ld_peak;
			out_resc_q <= ld_resc;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_peak_q, out_cnt_q, out_idx_q};
	assign m_tuser  = {out_resc_q, out_inr_q};

`ifndef SYNTHESIS
	// a rescale only ever comes from an accepted push
	a_resc_inr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_resc_q |-> out_inr_q)
		else $error("rescaled result without in_range");

	// the peak bounds every bin, before and after rescale
	a_peak_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_peak_q >= out_cnt_q)
		else $error("bin count above peak");

	// the rescale unit is started only when it is free
	a_sc_free: assert property (@(posedge clk) disable iff (!arst_n)
		sc_req.start |-> !sc_rsp.busy)
		else $error("rescale unit started while busy");

	// a waiting result is never overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || m_tready)
		else $error("output register overwritten");
`endif

endmodule

// ===== hdl/dsh_bin_ram.sv =====
// bin count memory, one write port and one registered read port
`timescale 1ns / 1ps

module dsh_bin_ram import dsh_pkg::*; #(
	parameter int DEPTH = BINS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [CNT_W-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [CNT_W-1:0] rd_data
);

	logic [CNT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/dsh_scaler.sv =====
// rescale unit: floor(x * num / den) saturated, one multiply then a bit-serial divide
`timescale 1ns / 1ps

module dsh_scaler import dsh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  scl_req_t         req,
	input  logic [CNT_W-1:0] num,
	input  logic [CNT_W-1:0] den,
	output scl_rsp_t         rsp
);

	scl_state_t state_q, state_d;

	logic [CNT_W-1:0]   x_q;
	logic [2*CNT_W-1:0] prod_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   quo_q;
	logic [4:0]         step_q;
	logic               done_q;

	logic               sat;
	logic [CNT_W:0]     shifted;
	logic               ge;
	logic [CNT_W:0]     diff;

	// quotient does not fit 32 bits when the high half reaches the divisor
	assign sat     = prod_q[2*CNT_W-1:CNT_W] >= den;
	assign shifted = {rem_q, quo_q[CNT_W-1]};
	assign ge      = shifted >= {1'b0, den};
	assign diff    = shifted - {1'b0, den};

	always_comb begin
		state_d = state_q;
		case (state_q)
			SC_IDLE: begin
				if (req.start) begin
					state_d = SC_MUL;
				end
			end
			SC_MUL: state_d = SC_CHK;
			SC_CHK: begin
				if (sat) begin
					state_d = SC_IDLE;
				end else begin
					state_d = SC_DIV;
				end
			end
			SC_DIV: begin
				if (step_q == 5'd31) begin
					state_d = SC_IDLE;
				end
			end
			default: state_d = SC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == SC_CHK && sat) || (state_q == SC_DIV && step_q == 5'd31);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SC_IDLE: begin
				if (req.start) begin
					x_q <= req.x;
				end
			end
			SC_MUL: prod_q <= (2*CNT_W)'(x_q) * (2*CNT_W)'(num);
			SC_CHK: begin
				rem_q  <= prod_q[2*CNT_W-1:CNT_W];
				quo_q  <= sat ? CNT_MAX : prod_q[CNT_W-1:0];
				step_q <= 5'd0;
			end
			SC_DIV: begin
				rem_q  <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
				quo_q  <= {quo_q[CNT_W-2:0], ge};
				step_q <= step_q + 5'd1;
			end
			default: ;
		endcase
	end

	assign rsp.busy = (state_q != SC_IDLE);
	assign rsp.done = done_q;
	assign rsp.y    = quo_q;

endmodule
